// ===== src/bcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared widths, types and constants of the barycentric coordinate pipeline.
// ----------------------------------------------------------------------------
package bcc_pkg;

   localparam int COORD_WIDTH      = 32;
   localparam int WEIGHT_FRAC_BITS = 24;
   localparam int WEIGHT_W         = 32;

   // exact intermediate widths
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int DOT_W   = PROD_W + 2;
   localparam int HALF_W  = DOT_W / 2;
   localparam int BIG_W   = 2 * DOT_W;
   localparam int GRAM_W  = BIG_W + 2;
   localparam int NUMER_W = GRAM_W + WEIGHT_FRAC_BITS;
   localparam int QUOT_W  = NUMER_W + 1;
   localparam int SUM_W   = QUOT_W + 2;
   localparam int STEP_W  = GRAM_W + NUMER_W;
   localparam int NUM_PRODS = 6;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [WEIGHT_W-1:0]    weight_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [DOT_W-1:0]       dot_type;
   typedef logic [DOT_W-1:0]              dmag_type;
   typedef logic signed [BIG_W:0]         big_type;
   typedef logic signed [GRAM_W-1:0]      gram_type;
   typedef logic [GRAM_W-1:0]             mag_type;
   typedef logic [NUMER_W-1:0]            numer_type;
   typedef logic signed [QUOT_W-1:0]      quot_type;
   typedef logic signed [SUM_W-1:0]       sum_type;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type corner_a_x;
      coord_type corner_a_y;
      coord_type corner_a_z;
      coord_type corner_b_x;
      coord_type corner_b_y;
      coord_type corner_b_z;
      coord_type corner_c_x;
      coord_type corner_c_y;
      coord_type corner_c_z;
   } tri_type;

   typedef struct packed {
      dot_type d00;
      dot_type d01;
      dot_type d11;
      dot_type d20;
      dot_type d21;
   } dots_type;

   typedef struct packed {
      gram_type den;
      gram_type num_v;
      gram_type num_w;
   } gram_out_type;

   typedef struct packed {
      logic neg_v;
      logic neg_w;
      logic degenerate;
   } div_ctl_type;

   typedef struct packed {
      quot_type quot_v;
      quot_type quot_w;
      logic     degenerate;
   } div_out_type;

   typedef struct packed {
      weight_type weight_u;
      weight_type weight_v;
      weight_type weight_w;
      logic       degenerate;
      logic       saturated;
   } rsp_payload_type;

endpackage
`default_nettype wire

// ===== src/bcc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_req_if / bcc_rsp_if
// Valid/ready channels carrying a point-triangle pair and its weights.
// ----------------------------------------------------------------------------
interface bcc_req_if;
   import bcc_pkg::*;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;
   coord_type corner_a_x;
   coord_type corner_a_y;
   coord_type corner_a_z;
   coord_type corner_b_x;
   coord_type corner_b_y;
   coord_type corner_b_z;
   coord_type corner_c_x;
   coord_type corner_c_y;
   coord_type corner_c_z;

   modport source(output valid, point_x, point_y, point_z, corner_a_x, corner_a_y,
                  corner_a_z, corner_b_x, corner_b_y, corner_b_z, corner_c_x,
                  corner_c_y, corner_c_z, input ready);
   modport sink(input valid, point_x, point_y, point_z, corner_a_x, corner_a_y,
                corner_a_z, corner_b_x, corner_b_y, corner_b_z, corner_c_x,
                corner_c_y, corner_c_z, output ready);
endinterface

interface bcc_rsp_if;
   import bcc_pkg::*;
   logic       valid;
   logic       ready;
   weight_type weight_u;
   weight_type weight_v;
   weight_type weight_w;
   logic       degenerate;
   logic       saturated;

   modport source(output valid, weight_u, weight_v, weight_w, degenerate, saturated,
                  input ready);
   modport sink(input valid, weight_u, weight_v, weight_w, degenerate, saturated,
                output ready);
endinterface
`default_nettype wire

// ===== src/barycentric_coords_3d.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_coords_3d
// Barycentric weights of a 3D point against a triangle, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one point-triangle pair per cycle (Q16.16 coordinates) and returns the
// weights u, v, w in Q8.24 with degenerate and saturated flags. Throughput is
// one item per clock while the skid entry is free. The divider resolves one
// quotient bit per stage over the full exact numerator. All intermediate
// arithmetic is exact; quotients truncate toward zero. A zero Gram
// determinant yields zero weights with the degenerate flag. The result side
// ends in an output register plus one skid entry, so input ready depends only
// on internal state and a waiting result never blocks the next transfer until
// the skid entry fills.
// ----------------------------------------------------------------------------
module barycentric_coords_3d (
   input  logic      clock,
   input  logic      reset,
   bcc_req_if.sink   req_if,
   bcc_rsp_if.source rsp_if
);
   import bcc_pkg::*;

   logic            adv;
   tri_type         req_tri;
   logic            dot_valid;
   dots_type        dots;
   logic            gram_valid;
   gram_out_type    gram;
   logic            div_valid;
   div_out_type     div_res;
   sum_type         v_ext;
   sum_type         w_ext;
   sum_type         u_ext;
   logic            fin_valid_ff;
   rsp_payload_type fin_ff;
   rsp_payload_type fin_in;
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   logic            skid_valid_ff;
   rsp_payload_type skid_ff;
   logic            push;
   logic            pop;

   // whole pipeline advances while the skid entry is free
   assign adv         = ~skid_valid_ff;
   assign req_if.ready = adv;

   always_comb begin
      req_tri.point_x    = req_if.point_x;
      req_tri.point_y    = req_if.point_y;
      req_tri.point_z    = req_if.point_z;
      req_tri.corner_a_x = req_if.corner_a_x;
      req_tri.corner_a_y = req_if.corner_a_y;
      req_tri.corner_a_z = req_if.corner_a_z;
      req_tri.corner_b_x = req_if.corner_b_x;
      req_tri.corner_b_y = req_if.corner_b_y;
      req_tri.corner_b_z = req_if.corner_b_z;
      req_tri.corner_c_x = req_if.corner_c_x;
      req_tri.corner_c_y = req_if.corner_c_y;
      req_tri.corner_c_z = req_if.corner_c_z;
   end

   bcc_dot u_dot (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_if.valid),
      .in_tri   (req_tri),
      .out_valid(dot_valid),
      .out_dots (dots)
   );

   bcc_gram u_gram (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (dot_valid),
      .in_dots  (dots),
      .out_valid(gram_valid),
      .out_gram (gram)
   );

   bcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (gram_valid),
      .in_gram  (gram),
      .out_valid(div_valid),
      .out_div  (div_res)
   );

   // true when the value fits the signed weight range
   function automatic logic weight_fits(sum_type x);
      return x[SUM_W-1:WEIGHT_W-1] == {(SUM_W-WEIGHT_W+1){x[WEIGHT_W-1]}};
   endfunction

   // clip to the signed weight range
   function automatic weight_type weight_clip(sum_type x);
      weight_type r;
      if (weight_fits(x)) begin
         r = x[WEIGHT_W-1:0];
      end else if (x[SUM_W-1]) begin
         r = {1'b1, {(WEIGHT_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(WEIGHT_W-1){1'b1}}};
      end
      return r;
   endfunction

   // form u exactly from the truncated quotients, then clip each weight
   always_comb begin
      v_ext = sum_type'(div_res.quot_v);
      w_ext = sum_type'(div_res.quot_w);
      u_ext = sum_type'({1'b0, WEIGHT_ONE}) - v_ext - w_ext;
      if (div_res.degenerate) begin
         fin_in.weight_u   = '0;
         fin_in.weight_v   = '0;
         fin_in.weight_w   = '0;
         fin_in.degenerate = 1'b1;
         fin_in.saturated  = 1'b0;
      end else begin
         fin_in.weight_u   = weight_clip(u_ext);
         fin_in.weight_v   = weight_clip(v_ext);
         fin_in.weight_w   = weight_clip(w_ext);
         fin_in.degenerate = 1'b0;
         fin_in.saturated  = ~(weight_fits(u_ext) & weight_fits(v_ext) & weight_fits(w_ext));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff <= fin_in;
      end
   end

   // output register with one skid entry behind it
   assign push = adv & fin_valid_ff;
   assign pop  = out_valid_ff & rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         // drain the skid entry first
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_ff <= push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || pop) begin
         out_ff <= fin_ff;
      end else if (push) begin
         skid_ff <= fin_ff;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.weight_u   = out_ff.weight_u;
   assign rsp_if.weight_v   = out_ff.weight_v;
   assign rsp_if.weight_w   = out_ff.weight_w;
   assign rsp_if.degenerate = out_ff.degenerate;
   assign rsp_if.saturated  = out_ff.saturated;
endmodule
`default_nettype wire

// ===== src/bcc_dot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_dot
// Edge vectors, component products and the five dot products (3 stages).
// ----------------------------------------------------------------------------
module bcc_dot (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  bcc_pkg::tri_type  in_tri,
   output logic              out_valid,
   output bcc_pkg::dots_type out_dots
);
   import bcc_pkg::*;

   logic [2:0]  vld_ff;
   diff_type    e0_ff [3];
   diff_type    e1_ff [3];
   diff_type    q_ff  [3];
   prod_type    p00_ff [3];
   prod_type    p01_ff [3];
   prod_type    p11_ff [3];
   prod_type    p20_ff [3];
   prod_type    p21_ff [3];
   dots_type    dots_ff;
   dots_type    dots_in;
   coord_type   pc [3];
   coord_type   ac [3];
   coord_type   bc [3];
   coord_type   cc [3];

   always_comb begin
      pc[0] = in_tri.point_x;    pc[1] = in_tri.point_y;    pc[2] = in_tri.point_z;
      ac[0] = in_tri.corner_a_x; ac[1] = in_tri.corner_a_y; ac[2] = in_tri.corner_a_z;
      bc[0] = in_tri.corner_b_x; bc[1] = in_tri.corner_b_y; bc[2] = in_tri.corner_b_z;
      cc[0] = in_tri.corner_c_x; cc[1] = in_tri.corner_c_y; cc[2] = in_tri.corner_c_z;
   end

   always_comb begin
      dots_in.d00 = dot_type'(p00_ff[0]) + dot_type'(p00_ff[1]) + dot_type'(p00_ff[2]);
      dots_in.d01 = dot_type'(p01_ff[0]) + dot_type'(p01_ff[1]) + dot_type'(p01_ff[2]);
      dots_in.d11 = dot_type'(p11_ff[0]) + dot_type'(p11_ff[1]) + dot_type'(p11_ff[2]);
      dots_in.d20 = dot_type'(p20_ff[0]) + dot_type'(p20_ff[1]) + dot_type'(p20_ff[2]);
      dots_in.d21 = dot_type'(p21_ff[0]) + dot_type'(p21_ff[1]) + dot_type'(p21_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            e0_ff[k]  <= diff_type'(bc[k]) - diff_type'(ac[k]);
            e1_ff[k]  <= diff_type'(cc[k]) - diff_type'(ac[k]);
            q_ff[k]   <= diff_type'(pc[k]) - diff_type'(ac[k]);
            p00_ff[k] <= prod_type'(e0_ff[k]) * prod_type'(e0_ff[k]);
            p01_ff[k] <= prod_type'(e0_ff[k]) * prod_type'(e1_ff[k]);
            p11_ff[k] <= prod_type'(e1_ff[k]) * prod_type'(e1_ff[k]);
            p20_ff[k] <= prod_type'(q_ff[k])  * prod_type'(e0_ff[k]);
            p21_ff[k] <= prod_type'(q_ff[k])  * prod_type'(e1_ff[k]);
         end
         dots_ff <= dots_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_dots  = dots_ff;
endmodule
`default_nettype wire

// ===== src/bcc_gram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_gram
// Gram determinant and the two numerators from split wide products (3 stages).
// ----------------------------------------------------------------------------
module bcc_gram (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  bcc_pkg::dots_type     in_dots,
   output logic                  out_valid,
   output bcc_pkg::gram_out_type out_gram
);
   import bcc_pkg::*;

   logic [2:0]   vld_ff;
   dot_type      opa [NUM_PRODS];
   dot_type      opb [NUM_PRODS];
   dmag_type     ma  [NUM_PRODS];
   dmag_type     mb  [NUM_PRODS];
   dmag_type     ll_ff [NUM_PRODS];
   dmag_type     lh_ff [NUM_PRODS];
   dmag_type     hl_ff [NUM_PRODS];
   dmag_type     hh_ff [NUM_PRODS];
   logic         neg_ff [NUM_PRODS];
   big_type      big_in [NUM_PRODS];
   big_type      big_ff [NUM_PRODS];
   gram_out_type gram_ff;
   gram_out_type gram_in;

   // product order: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
   always_comb begin
      opa[0] = in_dots.d00; opb[0] = in_dots.d11;
      opa[1] = in_dots.d01; opb[1] = in_dots.d01;
      opa[2] = in_dots.d11; opb[2] = in_dots.d20;
      opa[3] = in_dots.d01; opb[3] = in_dots.d21;
      opa[4] = in_dots.d00; opb[4] = in_dots.d21;
      opa[5] = in_dots.d01; opb[5] = in_dots.d20;
      for (int j = 0; j < NUM_PRODS; j++) begin
         ma[j] = opa[j][DOT_W-1] ? dmag_type'(-opa[j]) : dmag_type'(opa[j]);
         mb[j] = opb[j][DOT_W-1] ? dmag_type'(-opb[j]) : dmag_type'(opb[j]);
      end
   end

   // recombine the four partial products, then restore the sign
   always_comb begin
      logic [BIG_W-1:0] mag;
      for (int j = 0; j < NUM_PRODS; j++) begin
         mag = {hh_ff[j], ll_ff[j]} + (BIG_W'(lh_ff[j]) << HALF_W)
               + (BIG_W'(hl_ff[j]) << HALF_W);
         big_in[j] = neg_ff[j] ? -big_type'({1'b0, mag}) : big_type'({1'b0, mag});
      end
   end

   always_comb begin
      gram_in.den   = gram_type'(big_ff[0]) - gram_type'(big_ff[1]);
      gram_in.num_v = gram_type'(big_ff[2]) - gram_type'(big_ff[3]);
      gram_in.num_w = gram_type'(big_ff[4]) - gram_type'(big_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NUM_PRODS; j++) begin
            ll_ff[j]  <= DOT_W'(ma[j][HALF_W-1:0]) * DOT_W'(mb[j][HALF_W-1:0]);
            lh_ff[j]  <= DOT_W'(ma[j][HALF_W-1:0]) * DOT_W'(mb[j][DOT_W-1:HALF_W]);
            hl_ff[j]  <= DOT_W'(ma[j][DOT_W-1:HALF_W]) * DOT_W'(mb[j][HALF_W-1:0]);
            hh_ff[j]  <= DOT_W'(ma[j][DOT_W-1:HALF_W]) * DOT_W'(mb[j][DOT_W-1:HALF_W]);
            neg_ff[j] <= opa[j][DOT_W-1] ^ opb[j][DOT_W-1];
            big_ff[j] <= big_in[j];
         end
         gram_ff <= gram_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_gram  = gram_ff;
endmodule
`default_nettype wire

// ===== src/bcc_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_div
// Pipelined restoring divider, one quotient bit per stage, v and w side by side.
// ----------------------------------------------------------------------------
module bcc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  bcc_pkg::gram_out_type in_gram,
   output logic                  out_valid,
   output bcc_pkg::div_out_type  out_div
);
   import bcc_pkg::*;

   logic [NUMER_W+1:0] vld_ff;
   mag_type            rem_v_ff [NUMER_W+1];
   mag_type            rem_w_ff [NUMER_W+1];
   numer_type          nq_v_ff  [NUMER_W+1];
   numer_type          nq_w_ff  [NUMER_W+1];
   mag_type            dmag_ff  [NUMER_W+1];
   div_ctl_type        ctl_ff   [NUMER_W+1];
   logic [STEP_W-1:0]  step_v   [NUMER_W];
   logic [STEP_W-1:0]  step_w   [NUMER_W];
   div_ctl_type        ctl_in;
   mag_type            dmag_in;
   mag_type            nmag_v;
   mag_type            nmag_w;
   div_out_type        div_ff;
   div_out_type        div_in;

   // shift in one numerator bit, subtract the divisor when it fits
   function automatic logic [STEP_W-1:0] div_step(mag_type rem, numer_type nq, mag_type d);
      logic [GRAM_W:0]   trial;
      logic [GRAM_W+1:0] diff;
      logic              qbit;
      mag_type           rem_next;
      trial    = {rem, nq[NUMER_W-1]};
      diff     = {1'b0, trial} - {2'b00, d};
      qbit     = ~diff[GRAM_W+1];
      rem_next = qbit ? diff[GRAM_W-1:0] : trial[GRAM_W-1:0];
      return {rem_next, nq[NUMER_W-2:0], qbit};
   endfunction

   always_comb begin
      dmag_in = in_gram.den[GRAM_W-1]   ? mag_type'(-in_gram.den)   : mag_type'(in_gram.den);
      nmag_v  = in_gram.num_v[GRAM_W-1] ? mag_type'(-in_gram.num_v) : mag_type'(in_gram.num_v);
      nmag_w  = in_gram.num_w[GRAM_W-1] ? mag_type'(-in_gram.num_w) : mag_type'(in_gram.num_w);
      ctl_in.neg_v      = in_gram.num_v[GRAM_W-1] ^ in_gram.den[GRAM_W-1];
      ctl_in.neg_w      = in_gram.num_w[GRAM_W-1] ^ in_gram.den[GRAM_W-1];
      ctl_in.degenerate = (in_gram.den == '0);
   end

   always_comb begin
      for (int i = 0; i < NUMER_W; i++) begin
         step_v[i] = div_step(rem_v_ff[i], nq_v_ff[i], dmag_ff[i]);
         step_w[i] = div_step(rem_w_ff[i], nq_w_ff[i], dmag_ff[i]);
      end
   end

   always_comb begin
      div_in.quot_v = ctl_ff[NUMER_W].neg_v ? -quot_type'(nq_v_ff[NUMER_W])
                                            : quot_type'(nq_v_ff[NUMER_W]);
      div_in.quot_w = ctl_ff[NUMER_W].neg_w ? -quot_type'(nq_w_ff[NUMER_W])
                                            : quot_type'(nq_w_ff[NUMER_W]);
      div_in.degenerate = ctl_ff[NUMER_W].degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUMER_W:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_v_ff[0] <= '0;
         rem_w_ff[0] <= '0;
         nq_v_ff[0]  <= {nmag_v, {WEIGHT_FRAC_BITS{1'b0}}};
         nq_w_ff[0]  <= {nmag_w, {WEIGHT_FRAC_BITS{1'b0}}};
         dmag_ff[0]  <= dmag_in;
         ctl_ff[0]   <= ctl_in;
         for (int i = 0; i < NUMER_W; i++) begin
            rem_v_ff[i+1] <= step_v[i][STEP_W-1:NUMER_W];
            nq_v_ff[i+1]  <= step_v[i][NUMER_W-1:0];
            rem_w_ff[i+1] <= step_w[i][STEP_W-1:NUMER_W];
            nq_w_ff[i+1]  <= step_w[i][NUMER_W-1:0];
            dmag_ff[i+1]  <= dmag_ff[i];
            ctl_ff[i+1]   <= ctl_ff[i];
         end
         div_ff <= div_in;
      end
   end

   assign out_valid = vld_ff[NUMER_W+1];
   assign out_div   = div_ff;
endmodule
`default_nettype wire

// ===== src/bcc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the result channel of the barycentric pipeline.
// ----------------------------------------------------------------------------
module bcc_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input bcc_pkg::weight_type rsp_weight_u,
   input bcc_pkg::weight_type rsp_weight_v,
   input bcc_pkg::weight_type rsp_weight_w,
   input logic                rsp_degenerate,
   input logic                rsp_saturated
);
   import bcc_pkg::*;

   logic [WEIGHT_W-1:0] weight_sum;
   assign weight_sum = rsp_weight_u + rsp_weight_v + rsp_weight_w;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_weight_u)
         && $stable(rsp_weight_v) && $stable(rsp_weight_w))
      else $error("result changed while stalled");

   // degenerate triangle gives zero weights and no clipping
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_weight_u == '0 && rsp_weight_v == '0
         && rsp_weight_w == '0 && !rsp_saturated)
      else $error("degenerate result with nonzero weights");

   // unclipped weights sum exactly to one
   a_partition: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate && !rsp_saturated |-> weight_sum == WEIGHT_ONE)
      else $error("weights do not sum to one");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind barycentric_coords_3d bcc_checker u_bcc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_weight_u  (rsp_if.weight_u),
   .rsp_weight_v  (rsp_if.weight_v),
   .rsp_weight_w  (rsp_if.weight_w),
   .rsp_degenerate(rsp_if.degenerate),
   .rsp_saturated (rsp_if.saturated)
);
`default_nettype wire
